// File: design/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
package tksd_pkg;

   localparam int ByteW   = 8;
   localparam int KindW   = 5;
   localparam int DetailW = 5;

   localparam logic [ByteW-1:0] ByteBksp   = 8'h7F;
   localparam logic [ByteW-1:0] ByteTab    = 8'd9;
   localparam logic [ByteW-1:0] ByteEnter  = 8'd13;
   localparam logic [ByteW-1:0] ByteEsc    = 8'd27;
   localparam logic [ByteW-1:0] ByteBrack  = 8'h5B;  // '['
   localparam logic [ByteW-1:0] ByteSs3    = 8'h4F;  // 'O'
   localparam logic [ByteW-1:0] ByteTilde  = 8'h7E;  // '~'
   localparam logic [ByteW-1:0] ByteSemi   = 8'h3B;  // ';'
   localparam logic [ByteW-1:0] ByteDig0   = 8'h30;
   localparam logic [ByteW-1:0] ByteDig1   = 8'h31;
   localparam logic [ByteW-1:0] ByteDig2   = 8'h32;
   localparam logic [ByteW-1:0] ByteDig3   = 8'h33;
   localparam logic [ByteW-1:0] ByteDig4   = 8'h34;
   localparam logic [ByteW-1:0] ByteDig5   = 8'h35;
   localparam logic [ByteW-1:0] ByteDig7   = 8'h37;
   localparam logic [ByteW-1:0] ByteDig8   = 8'h38;
   localparam logic [ByteW-1:0] ByteDig9   = 8'h39;
   localparam logic [ByteW-1:0] ByteA      = 8'h41;
   localparam logic [ByteW-1:0] ByteB      = 8'h42;
   localparam logic [ByteW-1:0] ByteC      = 8'h43;
   localparam logic [ByteW-1:0] ByteD      = 8'h44;
   localparam logic [ByteW-1:0] ByteF      = 8'h46;
   localparam logic [ByteW-1:0] ByteH      = 8'h48;
   localparam logic [ByteW-1:0] ByteP      = 8'h50;
   localparam logic [ByteW-1:0] ByteS      = 8'h53;

   typedef enum logic [KindW-1:0] {
      KIND_PLAIN  = 5'd0,
      KIND_BKSP   = 5'd1,
      KIND_TAB    = 5'd2,
      KIND_ENTER  = 5'd3,
      KIND_CTRL   = 5'd4,
      KIND_ESC    = 5'd5,
      KIND_UP     = 5'd6,
      KIND_DOWN   = 5'd7,
      KIND_RIGHT  = 5'd8,
      KIND_LEFT   = 5'd9,
      KIND_HOME   = 5'd10,
      KIND_END    = 5'd11,
      KIND_INS    = 5'd12,
      KIND_DEL    = 5'd13,
      KIND_PGUP   = 5'd14,
      KIND_PGDN   = 5'd15,
      KIND_FKEY   = 5'd16,
      KIND_CUP    = 5'd17,
      KIND_CDOWN  = 5'd18,
      KIND_CRIGHT = 5'd19,
      KIND_CLEFT  = 5'd20,
      KIND_CEND   = 5'd21,
      KIND_CHOME  = 5'd22
   } key_kind_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             timed_out;
   } req_item_type;

   typedef struct packed {
      logic [KindW-1:0]   key_kind;
      logic [DetailW-1:0] key_detail;
      logic [ByteW-1:0]   char_byte;
   } rsp_item_type;

endpackage

// File: design/terminal_key_sequence_decoder.sv
// Terminal key sequence decoder: raw input bytes to key events.
//
// Takes one input byte (or timeout mark) per item and returns at most one key
// event per item. An item is accepted every cycle while the result side keeps
// up; each item is held in the input register and its event, if any, is
// registered into the result register as the item leaves it. The decode of
// one item is a single table match against the escape state left by the
// previous item. ESC and the inner bytes of an escape form give no event; the
// completing or breaking byte gives the key, or escape when the form does not
// match. A timeout inside a form acts as a byte that never matches; a timeout
// while idle gives nothing.
module terminal_key_sequence_decoder
   import tksd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   typedef enum logic [2:0] {
      SEQ_IDLE  = 3'd0,
      SEQ_X     = 3'd1,
      SEQ_Y     = 3'd2,
      SEQ_D2    = 3'd3,
      SEQ_TILDE = 3'd4,
      SEQ_MOD   = 3'd5,
      SEQ_KEY   = 3'd6
   } seq_type;

   seq_type          stage_ff, stage_in;
   logic [ByteW-1:0] first_ff, first_in;
   logic [ByteW-1:0] second_ff, second_in;
   logic [ByteW-1:0] third_ff, third_in;

   logic             in_valid_ff, in_valid_in;
   req_item_type     in_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff;

   logic             emit;
   key_kind_type     kind;
   logic [DetailW-1:0] detail;
   logic [ByteW-1:0] chr;
   logic [ByteW-1:0] b;
   logic             advance;
   logic             take;

   function automatic logic is_digit(input logic [ByteW-1:0] v);
      return v inside {[ByteDig0:ByteDig9]};
   endfunction

   function automatic key_kind_type nav_kind(input logic [ByteW-1:0] v);
      key_kind_type k;
      case (v)
         ByteA:   k = KIND_UP;
         ByteB:   k = KIND_DOWN;
         ByteC:   k = KIND_RIGHT;
         ByteD:   k = KIND_LEFT;
         default: k = KIND_ESC;
      endcase
      return k;
   endfunction

   // F5 to F12 from the two digits of a "[dd~" form; zero when none
   function automatic logic [DetailW-1:0] fkey_num(input logic [ByteW-1:0] d1,
                                                   input logic [ByteW-1:0] d2);
      logic [DetailW-1:0] f;
      f = '0;
      if (d1 == ByteDig1) begin
         case (d2)
            ByteDig5: f = 5'd5;
            ByteDig7: f = 5'd6;
            ByteDig8: f = 5'd7;
            ByteDig9: f = 5'd8;
            default:  f = '0;
         endcase
      end else if (d1 == ByteDig2) begin
         case (d2)
            ByteDig0: f = 5'd9;
            ByteDig1: f = 5'd10;
            ByteDig3: f = 5'd11;
            ByteDig4: f = 5'd12;
            default:  f = '0;
         endcase
      end
      return f;
   endfunction

   function automatic key_kind_type tilde_kind(input logic [ByteW-1:0] d);
      key_kind_type k;
      case (d)
         ByteDig1:           k = KIND_HOME;
         ByteDig2:           k = KIND_INS;
         ByteDig3:           k = KIND_DEL;
         ByteDig4:           k = KIND_END;
         ByteDig5:           k = KIND_PGUP;
         8'h36:              k = KIND_PGDN;
         ByteDig7:           k = KIND_HOME;
         ByteDig8:           k = KIND_END;
         default:            k = KIND_ESC;
      endcase
      return k;
   endfunction

   function automatic key_kind_type mod_kind(input logic [ByteW-1:0] m,
                                             input logic [ByteW-1:0] k);
      key_kind_type r;
      r = KIND_ESC;
      if (m == ByteDig5) begin
         case (k)
            ByteA:   r = KIND_CUP;
            ByteB:   r = KIND_CDOWN;
            ByteC:   r = KIND_CRIGHT;
            ByteD:   r = KIND_CLEFT;
            ByteF:   r = KIND_CEND;
            ByteH:   r = KIND_CHOME;
            default: r = KIND_ESC;
         endcase
      end
      return r;
   endfunction

   assign b = in_item_ff.timed_out ? '0 : in_item_ff.in_byte;

   always_comb begin
      stage_in  = SEQ_IDLE;
      first_in  = first_ff;
      second_in = second_ff;
      third_in  = third_ff;
      emit      = 1'b0;
      kind      = KIND_ESC;
      detail    = '0;
      chr       = '0;
      case (stage_ff)
         SEQ_X: begin
            first_in = b;
            stage_in = SEQ_Y;
         end
         SEQ_Y: begin
            second_in = b;
            emit      = 1'b1;
            if (first_ff == ByteBrack) begin
               if (is_digit(b)) begin
                  emit     = 1'b0;
                  stage_in = SEQ_D2;
               end else if (nav_kind(b) != KIND_ESC) begin
                  kind = nav_kind(b);
               end else if (b == ByteF) begin
                  kind = KIND_END;
               end else if (b == ByteH) begin
                  kind = KIND_HOME;
               end
            end else if (first_ff == ByteSs3) begin
               if (nav_kind(b) != KIND_ESC) begin
                  kind = nav_kind(b);
               end else if (b inside {[ByteP:ByteS]}) begin
                  kind   = KIND_FKEY;
                  detail = DetailW'(b - ByteP) + 5'd1;
               end
            end
         end
         SEQ_D2: begin
            third_in = b;
            if (b == ByteTilde) begin
               emit = 1'b1;
               kind = tilde_kind(second_ff);
            end else if (is_digit(b)) begin
               stage_in = SEQ_TILDE;
            end else if (b == ByteSemi) begin
               stage_in = SEQ_MOD;
            end else begin
               emit = 1'b1;
            end
         end
         SEQ_TILDE: begin
            emit = 1'b1;
            if (b == ByteTilde && fkey_num(second_ff, third_ff) != '0) begin
               kind   = KIND_FKEY;
               detail = fkey_num(second_ff, third_ff);
            end
         end
         SEQ_MOD: begin
            third_in = b;
            stage_in = SEQ_KEY;
         end
         SEQ_KEY: begin
            emit = 1'b1;
            kind = mod_kind(third_ff, b);
         end
         default: begin
            // idle: timeout gives nothing, ESC opens a form
            if (!in_item_ff.timed_out) begin
               emit = 1'b1;
               if (b == ByteBksp) begin
                  kind = KIND_BKSP;
               end else if (b == ByteTab) begin
                  kind = KIND_TAB;
               end else if (b == ByteEnter) begin
                  kind = KIND_ENTER;
               end else if (b inside {[8'd1:8'd26]}) begin
                  kind   = KIND_CTRL;
                  detail = b[DetailW-1:0];
               end else if (b == ByteEsc) begin
                  emit     = 1'b0;
                  stage_in = SEQ_X;
               end else begin
                  kind = KIND_PLAIN;
                  chr  = b;
               end
            end
         end
      endcase
   end

   // an item leaves the input register once its event, if any, has a place
   assign advance      = in_valid_ff && (!emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign take         = req_valid && !req_stall;
   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stage_ff     <= SEQ_IDLE;
         first_ff     <= '0;
         second_ff    <= '0;
         third_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            stage_ff  <= stage_in;
            first_ff  <= first_in;
            second_ff <= second_in;
            third_ff  <= third_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
      if (advance && emit) begin
         rsp_item_ff.key_kind   <= kind;
         rsp_item_ff.key_detail <= detail;
         rsp_item_ff.char_byte  <= chr;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef ASSERT_OFF
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_item_ff.key_kind <= KIND_CHOME)
      else $error("key kind out of range");

   a_char_plain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.char_byte != '0) |-> rsp_item_ff.key_kind == KIND_PLAIN)
      else $error("character byte on a non-plain key");

   a_detail_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.key_detail != '0) |->
      (rsp_item_ff.key_kind == KIND_CTRL || rsp_item_ff.key_kind == KIND_FKEY))
      else $error("detail on a key that carries none");

   a_idle_timeout: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && stage_ff == SEQ_IDLE && in_item_ff.timed_out) |-> !emit)
      else $error("idle timeout produced an event");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && emit && rsp_valid_ff))
      else $error("input stalled without a blocked event");
`endif

endmodule

// File: bench/terminal_key_sequence_decoder_test.sv
// Self-checking testbench for the terminal key sequence decoder.
module terminal_key_sequence_decoder_test
   import tksd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TargetItems   = 1650;
   localparam int WatchdogLimit = 2000;
   localparam int HoldOffCycles = 400;
   localparam int TailCycles    = 8;

   localparam logic [ByteW-1:0] ByteCtrlA = 8'd1;
   localparam logic [ByteW-1:0] ByteCtrlZ = 8'd26;
   localparam logic [ByteW-1:0] ByteDig6  = 8'h36;

   typedef enum logic [2:0] {
      StIdle       = 3'd0,
      StAfterEsc   = 3'd1,
      StPair       = 3'd2,
      StAfterDigit = 3'd3,
      StWantTilde  = 3'd4,
      StWantMod    = 3'd5,
      StWantLetter = 3'd6
   } esc_stage_type;

   // Tracks the escape state of the byte stream and the key events still owed.
   class keystroke_ledger;
      esc_stage_type    stage;
      logic [ByteW-1:0] first_byte;
      logic [ByteW-1:0] second_byte;
      logic [ByteW-1:0] third_byte;
      rsp_item_type     awaited[$];
      int unsigned      failures;

      function new();
         stage       = StIdle;
         first_byte  = '0;
         second_byte = '0;
         third_byte  = '0;
         failures    = 0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function void push_key(key_kind_type kind, logic [DetailW-1:0] detail = '0,
                             logic [ByteW-1:0] ch = '0);
         rsp_item_type r;
         r.key_kind   = kind;
         r.key_detail = detail;
         r.char_byte  = ch;
         awaited.push_back(r);
         stage = StIdle;
      endfunction

      function bit is_digit(logic [ByteW-1:0] b);
         return b >= ByteDig0 && b <= ByteDig9;
      endfunction

      // KIND_PLAIN stands for no arrow letter
      function key_kind_type arrow_of(logic [ByteW-1:0] b);
         case (b)
            ByteA:   return KIND_UP;
            ByteB:   return KIND_DOWN;
            ByteC:   return KIND_RIGHT;
            ByteD:   return KIND_LEFT;
            default: return KIND_PLAIN;
         endcase
      endfunction

      function key_kind_type tilde_kind(logic [ByteW-1:0] d);
         case (d)
            ByteDig1: return KIND_HOME;
            ByteDig2: return KIND_INS;
            ByteDig3: return KIND_DEL;
            ByteDig4: return KIND_END;
            ByteDig5: return KIND_PGUP;
            ByteDig6: return KIND_PGDN;
            ByteDig7: return KIND_HOME;
            ByteDig8: return KIND_END;
            default:  return KIND_ESC;
         endcase
      endfunction

      // zero when the two digits name no function key
      function logic [DetailW-1:0] fkey_number(logic [ByteW-1:0] d1, logic [ByteW-1:0] d2);
         if (d1 == ByteDig1) begin
            case (d2)
               ByteDig5: return 5'd5;
               ByteDig7: return 5'd6;
               ByteDig8: return 5'd7;
               ByteDig9: return 5'd8;
               default:  return '0;
            endcase
         end else if (d1 == ByteDig2) begin
            case (d2)
               ByteDig0: return 5'd9;
               ByteDig1: return 5'd10;
               ByteDig3: return 5'd11;
               ByteDig4: return 5'd12;
               default:  return '0;
            endcase
         end
         return '0;
      endfunction

      function key_kind_type ctrl_nav_kind(logic [ByteW-1:0] m, logic [ByteW-1:0] k);
         if (m != ByteDig5) return KIND_ESC;
         case (k)
            ByteA:   return KIND_CUP;
            ByteB:   return KIND_CDOWN;
            ByteC:   return KIND_CRIGHT;
            ByteD:   return KIND_CLEFT;
            ByteF:   return KIND_CEND;
            ByteH:   return KIND_CHOME;
            default: return KIND_ESC;
         endcase
      endfunction

      function void note_input(req_item_type it);
         logic [ByteW-1:0]   b;
         key_kind_type       k;
         logic [DetailW-1:0] f;
         // a timeout inside a form behaves as a zero byte
         b = it.timed_out ? '0 : it.in_byte;
         case (stage)
            StAfterEsc: begin
               first_byte = b;
               stage      = StPair;
            end
            StPair: begin
               second_byte = b;
               k = arrow_of(b);
               if (first_byte == ByteBrack) begin
                  if (is_digit(b)) stage = StAfterDigit;
                  else if (k != KIND_PLAIN) push_key(k);
                  else if (b == ByteF) push_key(KIND_END);
                  else if (b == ByteH) push_key(KIND_HOME);
                  else push_key(KIND_ESC);
               end else if (first_byte == ByteSs3) begin
                  if (k != KIND_PLAIN) push_key(k);
                  else if (b >= ByteP && b <= ByteS)
                     push_key(KIND_FKEY, DetailW'(b - ByteP) + 5'd1);
                  else push_key(KIND_ESC);
               end else begin
                  push_key(KIND_ESC);
               end
            end
            StAfterDigit: begin
               third_byte = b;
               if (b == ByteTilde) push_key(tilde_kind(second_byte));
               else if (is_digit(b)) stage = StWantTilde;
               else if (b == ByteSemi) stage = StWantMod;
               else push_key(KIND_ESC);
            end
            StWantTilde: begin
               f = fkey_number(second_byte, third_byte);
               if (b == ByteTilde && f != 0) push_key(KIND_FKEY, f);
               else push_key(KIND_ESC);
            end
            StWantMod: begin
               third_byte = b;
               stage      = StWantLetter;
            end
            StWantLetter: push_key(ctrl_nav_kind(third_byte, b));
            default: begin
               stage = StIdle;
               if (!it.timed_out) begin
                  if (b == ByteBksp) push_key(KIND_BKSP);
                  else if (b == ByteTab) push_key(KIND_TAB);
                  else if (b == ByteEnter) push_key(KIND_ENTER);
                  else if (b >= ByteCtrlA && b <= ByteCtrlZ) push_key(KIND_CTRL, b[DetailW-1:0]);
                  else if (b == ByteEsc) stage = StAfterEsc;
                  else push_key(KIND_PLAIN, '0, b);
               end
            end
         endcase
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            $error("unexpected key event: key_kind %0d, key_detail %0d, char_byte 0x%02h",
                   got.key_kind, got.key_detail, got.char_byte);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.key_kind !== want.key_kind) begin
            $error("key_kind: expected %0d, got %0d", want.key_kind, got.key_kind);
            failures++;
         end
         if (got.key_detail !== want.key_detail) begin
            $error("key_detail: expected %0d, got %0d", want.key_detail, got.key_detail);
            failures++;
         end
         if (got.char_byte !== want.char_byte) begin
            $error("char_byte: expected 0x%02h, got 0x%02h", want.char_byte, got.char_byte);
            failures++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   keystroke_ledger ledger;
   int              items_sent;
   int              burst_left;
   int              quiet_cycles = 0;
   bit              hold_request;

   logic [ByteW-1:0] opening_bytes [24] = '{
      8'h00, 8'hFF, ByteBksp, ByteTab, ByteEnter, ByteCtrlA, ByteCtrlZ,
      ByteEsc, ByteBrack, ByteA,
      ByteEsc, ByteSs3, ByteP,
      ByteEsc, ByteBrack, ByteDig2, ByteDig4, ByteTilde,
      ByteEsc, ByteBrack, ByteDig1, ByteSemi, ByteDig5, ByteH
   };

   terminal_key_sequence_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Log accepted items on both sides and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) ledger.note_input(req_item);
         if (rsp_valid && !rsp_stall) ledger.check_result(rsp_item);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WatchdogLimit) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Result side: stall in patterns of random length, with one long hold-off on request.
   initial begin
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            if (hold_request) begin
               rsp_stall = 1'b1;
               repeat (HoldOffCycles) @(negedge clock);
               hold_request = 1'b0;
            end
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 3) == 0);
               2:       rsp_stall = ($urandom_range(0, 3) != 0);
               default: rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   function automatic req_item_type key_byte(logic [ByteW-1:0] b);
      req_item_type it;
      it.in_byte   = b;
      it.timed_out = 1'b0;
      return it;
   endfunction

   // the byte under a timeout mark is random, since the block must ignore it
   function automatic req_item_type timeout_mark();
      req_item_type it;
      it.in_byte   = ByteW'($urandom_range(0, 255));
      it.timed_out = 1'b1;
      return it;
   endfunction

   // now and then break a form with a stray byte or a timeout
   function automatic req_item_type maybe_spoil(logic [ByteW-1:0] b);
      case ($urandom_range(0, 23))
         0:       return timeout_mark();
         1:       return key_byte(ByteW'($urandom_range(0, 255)));
         default: return key_byte(b);
      endcase
   endfunction

   function automatic logic [ByteW-1:0] any_digit();
      return ByteDig0 + ByteW'($urandom_range(0, 9));
   endfunction

   function automatic logic [ByteW-1:0] final_letter();
      case ($urandom_range(0, 10))
         0:       return ByteA;
         1:       return ByteB;
         2:       return ByteC;
         3:       return ByteD;
         4:       return ByteF;
         5:       return ByteH;
         6:       return ByteP + ByteW'($urandom_range(0, 3));
         7:       return ByteTilde;
         default: return ByteW'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one item at the falling edge and hold it until accepted.
   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_item  = it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed key event has come back.
   task automatic wait_for_quiet();
      req_valid = 1'b0;
      do @(negedge clock); while (ledger.pending() != 0);
   endtask

   task automatic send_single();
      case ($urandom_range(0, 9))
         0, 1:    send_item(timeout_mark());
         2, 3:    send_item(key_byte(ByteW'($urandom_range(0, 31))));
         4:       send_item(key_byte($urandom_range(0, 1) ? ByteBksp : 8'hFF));
         default: send_item(key_byte(ByteW'($urandom_range(0, 255))));
      endcase
   endtask

   task automatic send_form();
      req_item_type seq[$];
      logic [ByteW-1:0] d;
      int n;
      seq.push_back(key_byte(ByteEsc));
      case ($urandom_range(0, 4))
         0: begin
            seq.push_back(maybe_spoil($urandom_range(0, 1) ? ByteBrack : ByteSs3));
            seq.push_back(maybe_spoil(final_letter()));
         end
         1: begin
            seq.push_back(maybe_spoil(ByteBrack));
            seq.push_back(maybe_spoil(any_digit()));
            seq.push_back(maybe_spoil(ByteTilde));
         end
         2: begin
            d = ($urandom_range(0, 3) == 0) ? any_digit()
                : ($urandom_range(0, 1) ? ByteDig1 : ByteDig2);
            seq.push_back(maybe_spoil(ByteBrack));
            seq.push_back(maybe_spoil(d));
            seq.push_back(maybe_spoil(any_digit()));
            seq.push_back(maybe_spoil(ByteTilde));
         end
         3: begin
            d = ($urandom_range(0, 3) == 0) ? any_digit() : ByteDig5;
            seq.push_back(maybe_spoil(ByteBrack));
            seq.push_back(maybe_spoil(any_digit()));
            seq.push_back(maybe_spoil(ByteSemi));
            seq.push_back(maybe_spoil(d));
            seq.push_back(maybe_spoil(final_letter()));
         end
         default: begin
            n = $urandom_range(1, 5);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) seq.push_back(timeout_mark());
               else seq.push_back(key_byte(ByteW'($urandom_range(0, 255))));
            end
         end
      endcase
      foreach (seq[i]) send_item(seq[i]);
   endtask

   initial begin
      bit hold_done;
      bit paused_once;
      ledger       = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_item     = '0;
      items_sent   = 0;
      burst_left   = 0;
      hold_request = 1'b0;
      hold_done    = 1'b0;
      paused_once  = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, every idle class and each escape form but the one-digit tilde form
      foreach (opening_bytes[i]) send_item(key_byte(opening_bytes[i]));
      send_item(timeout_mark());
      // a timeout straight after ESC still takes one more item before escape
      send_item(key_byte(ByteEsc));
      send_item(timeout_mark());
      send_item(key_byte(ByteA));
      wait_for_quiet();

      while (items_sent < TargetItems) begin
         if (!hold_done && items_sent >= 600) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (!paused_once && items_sent >= 1100) begin
            wait_for_quiet();
            paused_once = 1'b1;
         end
         if ($urandom_range(0, 19) < 11) send_form();
         else send_single();
      end

      wait_for_quiet();
      repeat (TailCycles) @(posedge clock);
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: terminal_key_sequence_decoder.f
design/tksd_pkg.sv
design/terminal_key_sequence_decoder.sv
bench/terminal_key_sequence_decoder_test.sv
